[design/iba_pkg.sv]
package iba_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam logic [6:0] NUM_BLOCKS_RST = 7'd64;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TAKEN   = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [5:0] index_request;
        logic [6:0] file_length;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] file_index;
        logic [5:0] blk_num;
        logic       block_valid;
        logic       last;
    } out_t;

    // Bitmap operation from the sequencer; addr is the full 6-bit block number.
    typedef struct packed {
        logic       clear;
        logic       set;
        logic [5:0] set_addr;
        logic [5:0] rd_addr;
    } map_op_t;

endpackage

[design/iba_map.sv]
module iba_map #(
    parameter int MAX_BLOCKS = iba_pkg::MAX_BLOCKS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  iba_pkg::map_op_t op,
    output logic            rd_bit
);
    import iba_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic [MAX_BLOCKS-1:0] used_map_reg;
    logic [MAX_BLOCKS-1:0] used_map_next;
    logic [AW-1:0]         set_idx;
    logic [AW-1:0]         rd_idx;

    // Addresses are cut to the bitmap width; bits read beyond the clamped block count go unused.
    assign set_idx = op.set_addr[AW-1:0];
    assign rd_idx  = op.rd_addr[AW-1:0];
    assign rd_bit  = used_map_reg[rd_idx];

    always_comb
    begin
        used_map_next = used_map_reg;
        if (op.clear)
        begin
            used_map_next = '0;
        end
        else if (op.set)
        begin
            used_map_next[set_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_map_reg <= '0;
        end
        else
        begin
            used_map_reg <= used_map_next;
        end
    end

endmodule

[design/iba_out.sv]
module iba_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  iba_pkg::out_t load_data,
    output logic          free,
    output logic          valid,
    input  logic          ready,
    output iba_pkg::out_t data
);
    import iba_pkg::*;

    logic valid_reg;
    logic valid_next;
    out_t data_reg;

    // Slot can take a new beat when empty or when the held beat leaves now.
    assign free  = !valid_reg || ready;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

[design/indexed_block_allocator.sv]
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     iba_pkg::in_t  (mode, index, length)
// out       output     out_valid / out_ready   iba_pkg::out_t (status, blocks, last)
// cfg       input      cfg_we                  num_blocks, 7 bits
//
// Clear request: taken in idle with no result beat.
// Range or taken error: the single result beat goes out through the response state.
// Allocation: a pass counting free blocks below the clamped block count, then a
//   bitmap scan one block a cycle, one beat per allocated block (a zero-length file
//   gets one empty beat). The bitmap and one bit-test/counter path set this pace;
//   out_ready low holds the scan at the next free block. Reset empties the bitmap at once.
module indexed_block_allocator #(
    parameter int MAX_BLOCKS = iba_pkg::MAX_BLOCKS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  iba_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output iba_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [6:0]    cfg_data
);
    import iba_pkg::*;

    localparam logic [6:0] MAX_NB = 7'(MAX_BLOCKS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_COUNT = 5'b00100,
        S_EMIT  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] num_blocks_reg;
    logic [5:0] idx_reg;
    logic [6:0] len_reg;
    logic [6:0] ptr_reg, ptr_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [6:0] k_reg, k_next;
    logic [1:0] status_reg, status_next;

    logic [6:0] nb_eff;
    logic       accept;
    logic       rd_bit;
    logic       blk_free;
    map_op_t    map_op;
    logic       out_load;
    out_t       out_load_data;
    logic       out_free;

    // Clamp the block count to the bitmap size.
    assign nb_eff   = (num_blocks_reg > MAX_NB) ? MAX_NB : num_blocks_reg;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // The index block counts as used while free blocks are counted,
    // before it is written to the map.
    assign blk_free = !rd_bit && (ptr_reg != {1'b0, idx_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg <= NUM_BLOCKS_RST;
        end
        else if (cfg_we)
        begin
            num_blocks_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        ptr_next           = ptr_reg;
        cnt_next           = cnt_reg;
        k_next             = k_reg;
        status_next        = status_reg;
        map_op.clear       = 1'b0;
        map_op.set         = 1'b0;
        map_op.set_addr    = ptr_reg[5:0];
        map_op.rd_addr     = ptr_reg[5:0];
        out_load           = 1'b0;
        out_load_data      = '0;
        out_load_data.file_index = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == MODE_CLEAR)
                    begin
                        map_op.clear = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                map_op.rd_addr = idx_reg;
                ptr_next       = '0;
                cnt_next       = '0;
                if ({1'b0, idx_reg} >= nb_eff)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_RESP;
                end
                else if (rd_bit)
                begin
                    status_next = ST_TAKEN;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (ptr_reg == nb_eff)
                begin
                    // Decide on the full count.
                    ptr_next = '0;
                    k_next   = '0;
                    if (cnt_reg < len_reg)
                    begin
                        status_next = ST_NOSPACE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        map_op.set      = 1'b1;
                        map_op.set_addr = idx_reg;
                        status_next     = ST_OK;
                        if (len_reg == '0)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + {6'd0, blk_free};
                    ptr_next = ptr_reg + 7'd1;
                end
            end
            S_EMIT:
            begin
                // Index bit is already in the map here; skip used blocks freely.
                if (rd_bit)
                begin
                    ptr_next = ptr_reg + 7'd1;
                end
                else if (out_free)
                begin
                    map_op.set                = 1'b1;
                    out_load                  = 1'b1;
                    out_load_data.status      = ST_OK;
                    out_load_data.blk_num     = ptr_reg[5:0];
                    out_load_data.block_valid = 1'b1;
                    out_load_data.last        = (k_reg == len_reg - 7'd1);
                    ptr_next                  = ptr_reg + 7'd1;
                    k_next                    = k_reg + 7'd1;
                    if (k_reg == len_reg - 7'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_load_data.status = status_reg;
                    out_load_data.last   = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the request and scan counters; payload regs need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= in_data.index_request;
            len_reg <= in_data.file_length;
        end
        ptr_reg    <= ptr_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        status_reg <= status_next;
    end

    iba_map #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (map_op),
        .rd_bit(rd_bit)
    );

    iba_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .load_data(out_load_data),
        .free     (out_free),
        .valid    (out_valid),
        .ready    (out_ready),
        .data     (out_data)
    );

    a_blk_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.block_valid |-> out_data.status == ST_OK)
        else $error("data block beat with error status");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.last && !out_data.block_valid)
        else $error("error beat not single and final");

    a_emit_k: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> k_reg < len_reg)
        else $error("emit past file length");

    a_count_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COUNT |-> ptr_reg <= nb_eff)
        else $error("count pointer beyond block count");

    a_emit_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> ptr_reg < nb_eff)
        else $error("emit scan ran off the bitmap");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import iba_pkg::*;

    // Map width and the quiet time after the last result beat. An allocation
    // counts free blocks and then scans the map, so two full map passes plus
    // margin covers any request still inside the block.
    localparam int MAP_BITS        = MAX_BLOCKS_DEF;
    localparam int SETTLE_CYC      = 2 * MAP_BITS + 8;
    localparam int QUIET_LIMIT     = 4000;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 38;

    // Block counts for the random phases; the last phase draws its own.
    localparam int PHASE_BLOCKS [RAND_PHASES-1] = '{64, 16, 3, 127, 40};

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    // One row of the directed table: a request or a block-count write. A row
    // marked typed carries its single result beat written out by hand.
    typedef struct {
        row_kind_t  kind;
        logic [6:0] cfg_value;
        in_t        req;
        bit         typed;
        out_t       typed_beat;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_t        in_data;
    logic       out_valid;
    logic       out_ready;
    out_t       out_data;
    logic       cfg_we;
    logic [6:0] cfg_data;

    // Shadow of the block: used/free map and the programmed block count.
    logic [MAP_BITS-1:0] block_map = '0;
    logic [6:0]          blocks_cfg = NUM_BLOCKS_RST;

    // Result beats still owed by the block, oldest first.
    out_t expected_beats[$];

    int  err_count   = 0;
    int  req_count   = 0;
    int  clear_count = 0;
    int  beat_count  = 0;
    int  cfg_count   = 0;
    bit  calm        = 1'b0;

    indexed_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Predict the effect of one accepted request: update the shadow map and,
    // if asked, queue the result beats it must produce.
    function automatic void allocate_file(input in_t req, input bit queue_beats);
        logic [MAP_BITS-1:0] trial;
        int   nb;
        int   need;
        int   free_cnt;
        int   k;
        int   i;
        out_t beat;
        // Block counts above the map width act as the full map.
        nb = (blocks_cfg > MAP_BITS) ? MAP_BITS : int'(blocks_cfg);
        need = int'(req.file_length);
        beat = '0;
        beat.file_index = req.index_request;
        beat.last = 1'b1;
        if (req.mode == MODE_CLEAR)
        begin
            block_map = '0;
            return;
        end
        if (int'(req.index_request) >= nb)
            beat.status = ST_RANGE;
        else if (block_map[req.index_request])
            beat.status = ST_TAKEN;
        else
        begin
            // Count free blocks below the block count, index block excluded.
            trial = block_map;
            trial[req.index_request] = 1'b1;
            free_cnt = 0;
            for (i = 0; i < nb; i++)
                if (!trial[i])
                    free_cnt++;
            if (free_cnt < need)
                beat.status = ST_NOSPACE;
            else
            begin
                beat.status = ST_OK;
                // Take the lowest free blocks, one beat each, last one flagged.
                k = 0;
                for (i = 0; i < nb && k < need; i++)
                begin
                    if (!trial[i])
                    begin
                        trial[i] = 1'b1;
                        beat.blk_num = 6'(i);
                        beat.block_valid = 1'b1;
                        beat.last = (k + 1 == need);
                        if (queue_beats)
                            expected_beats.push_back(beat);
                        k++;
                    end
                end
                block_map = trial;
                // A zero-length file still gets its one empty beat below.
                if (need != 0)
                    return;
            end
        end
        if (queue_beats)
            expected_beats.push_back(beat);
    endfunction

    function automatic dir_row_t req_row(input logic mode, input int idx, input int len);
        dir_row_t row;
        row = '{kind: ROW_REQ, cfg_value: '0, req: '0, typed: 1'b0, typed_beat: '0};
        row.req.mode = mode;
        row.req.index_request = 6'(idx);
        row.req.file_length = 7'(len);
        return row;
    endfunction

    // Allocate request whose single beat is known by inspection.
    function automatic dir_row_t chk_row(input int idx, input int len, input logic [1:0] status,
                                         input int blk, input logic valid);
        dir_row_t row;
        row = req_row(MODE_ALLOC, idx, len);
        row.typed = 1'b1;
        row.typed_beat.status = status;
        row.typed_beat.file_index = 6'(idx);
        row.typed_beat.blk_num = 6'(blk);
        row.typed_beat.block_valid = valid;
        row.typed_beat.last = 1'b1;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input int value);
        dir_row_t row;
        row = '{kind: ROW_CFG, cfg_value: 7'(value), req: '0, typed: 1'b0, typed_beat: '0};
        return row;
    endfunction

    // Present one request and hold it until accepted; predict on the accepting
    // edge. Valid stays high afterwards so the next request can follow
    // back to back; an idle burst drops it first.
    task automatic send_request(input in_t req, input bit typed, input out_t typed_beat);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        allocate_file(req, !typed);
        if (typed)
            expected_beats.push_back(typed_beat);
        req_count++;
        if (req.mode == MODE_CLEAR)
            clear_count++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 17))
                @(negedge clk);
        end
    endtask

    // Drop valid, wait for every owed beat, then let any beat-less work
    // (a clear, or the tail of a scan) finish before touching the register.
    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC)
            @(posedge clk);
    endtask

    task automatic write_blocks(input logic [6:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        blocks_cfg = value;
        cfg_count++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Result side: stall out_ready in random bursts, none in the calm phase.
    initial
    begin : result_pacing
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm)
                stall_left = 0;
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Check every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin : beat_check
        out_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            beat_count++;
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat", int'(out_data), 0);
            else
            begin
                want = expected_beats.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", out_data.status, want.status);
                if (out_data.file_index !== want.file_index)
                    report_mismatch("file_index", out_data.file_index, want.file_index);
                if (out_data.blk_num !== want.blk_num)
                    report_mismatch("blk_num", out_data.blk_num, want.blk_num);
                if (out_data.block_valid !== want.block_valid)
                    report_mismatch("block_valid", out_data.block_valid, want.block_valid);
                if (out_data.last !== want.last)
                    report_mismatch("last", out_data.last, want.last);
            end
        end
    end

    // Abort if no beat moves on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t   dir_table[$];
        dir_row_t   row;
        in_t        req;
        int         nb;
        logic [6:0] phase_val;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;

        // Directed part, full map of 64 after reset.
        dir_table.push_back(chk_row(0, 0, ST_OK, 0, 1'b0));       // empty file
        dir_table.push_back(chk_row(0, 1, ST_TAKEN, 0, 1'b0));    // index now used
        dir_table.push_back(chk_row(63, 64, ST_NOSPACE, 0, 1'b0));
        dir_table.push_back(req_row(MODE_ALLOC, 63, 62));          // fill the map exactly
        dir_table.push_back(chk_row(5, 0, ST_TAKEN, 0, 1'b0));
        dir_table.push_back(req_row(MODE_CLEAR, 42, 127));         // fields ignored
        dir_table.push_back(chk_row(10, 1, ST_OK, 0, 1'b1));      // lowest free block
        dir_table.push_back(req_row(MODE_ALLOC, 20, 3));
        dir_table.push_back(chk_row(63, 127, ST_NOSPACE, 0, 1'b0));
        // Shrink the map: higher used bits stay but are not scanned.
        dir_table.push_back(cfg_row(8));
        dir_table.push_back(chk_row(8, 0, ST_RANGE, 0, 1'b0));
        dir_table.push_back(req_row(MODE_ALLOC, 7, 3));            // takes the last free three
        dir_table.push_back(chk_row(6, 1, ST_TAKEN, 0, 1'b0));
        // No blocks at all: every index is out of range.
        dir_table.push_back(cfg_row(0));
        dir_table.push_back(chk_row(0, 0, ST_RANGE, 0, 1'b0));
        // Oversized count clamps to the full map.
        dir_table.push_back(cfg_row(127));
        dir_table.push_back(chk_row(63, 64, ST_NOSPACE, 0, 1'b0));
        // One-block map: only the index block fits.
        dir_table.push_back(cfg_row(1));
        dir_table.push_back(chk_row(0, 0, ST_TAKEN, 0, 1'b0));
        dir_table.push_back(req_row(MODE_CLEAR, 0, 0));
        dir_table.push_back(chk_row(0, 1, ST_NOSPACE, 0, 1'b0));
        dir_table.push_back(chk_row(0, 0, ST_OK, 0, 1'b0));
        // Longest burst: index in the middle, all remaining blocks allocated.
        dir_table.push_back(cfg_row(64));
        dir_table.push_back(req_row(MODE_CLEAR, 63, 0));
        dir_table.push_back(req_row(MODE_ALLOC, 33, 63));

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[r])
        begin
            row = dir_table[r];
            if (row.kind == ROW_CFG)
            begin
                drain_and_settle();
                write_blocks(row.cfg_value);
            end
            else
                send_request(row.req, row.typed, row.typed_beat);
        end

        // Random part: one block count per phase, mostly in-range indexes and
        // short files so the map keeps cycling between clears.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain_and_settle();
            if (p < RAND_PHASES - 1)
                phase_val = 7'(PHASE_BLOCKS[p]);
            else
                phase_val = 7'($urandom_range(0, 127));
            write_blocks(phase_val);
            calm = (p == RAND_PHASES - 1);
            nb = (phase_val > MAP_BITS) ? MAP_BITS : int'(phase_val);
            repeat (ITEMS_PER_PHASE)
            begin
                req.mode = ($urandom_range(0, 11) == 0) ? MODE_CLEAR : MODE_ALLOC;
                if (nb > 0 && $urandom_range(0, 3) != 0)
                    req.index_request = 6'($urandom_range(0, nb - 1));
                else
                    req.index_request = 6'($urandom_range(0, 63));
                case ($urandom_range(0, 9))
                    0:       req.file_length = 7'($urandom_range(0, 127));
                    1, 2:    req.file_length = 7'($urandom_range(0, nb));
                    default: req.file_length = 7'($urandom_range(0, 6));
                endcase
                send_request(req, 1'b0, '0);
            end
        end

        drain_and_settle();

        $display("covered %0d requests (%0d clears) over %0d block-count settings",
                 req_count, clear_count, cfg_count);
        $display("checked %0d result beats, %0d mismatches", beat_count, err_count);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
